// ===== rtl/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, angle constants, selection codes and stage payload types for
// the Cartesian to spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int COORD_W       = 32;
  localparam int ANG_FRAC      = 29;
  localparam int CORDIC_STAGES = 24;

  localparam int ACC_FRAC = 61;
  localparam int PRESCALE = 60 - COORD_W;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int ROOT_W   = COORD_W + PRESCALE;
  localparam int REM_W    = ROOT_W + 2;
  localparam int CD_W     = 64;
  localparam int ANG_W    = 64;
  localparam int YAW_W    = ANG_FRAC + 3;
  localparam int PITCH_W  = ANG_FRAC + 2;
  localparam int RND_SH   = ACC_FRAC - ANG_FRAC;

  localparam int LANES      = 2;
  localparam int LANE_XY    = 0;
  localparam int LANE_XYZ   = 1;
  localparam int LANE_YAW   = 0;
  localparam int LANE_PITCH = 1;

  localparam logic [ANG_W-1:0] PI_Q61         = 64'h6487ED5110B4611A;
  localparam logic [ANG_W-1:0] HALF_PI_Q61    = 64'h3243F6A8885A308D;
  localparam logic [ANG_W-1:0] QUARTER_PI_Q61 = 64'h1921FB54442D1847;
  localparam logic [ANG_W-1:0] RND_HALF       = ANG_W'(1) << (RND_SH - 1);

  localparam logic signed [YAW_W-1:0] YAW_LIMIT =
      YAW_W'((PI_Q61 + RND_HALF) >> RND_SH);
  localparam logic signed [PITCH_W-1:0] PITCH_LIMIT =
      PITCH_W'((HALF_PI_Q61 + RND_HALF) >> RND_SH);

  // How the final angle is formed from the CORDIC result
  typedef enum logic [2:0] {
    SEL_CORDIC,
    SEL_ZERO,
    SEL_HALF_PI,
    SEL_PI,
    SEL_PI_MINUS
  } c2s_sel_e;

  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] az;
    c2s_sel_e           yaw_sel;
    c2s_sel_e           pitch_sel;
    logic               yaw_neg;
    logic               pitch_neg;
  } c2s_side_t;

  typedef struct packed {
    c2s_sel_e           yaw_sel;
    c2s_sel_e           pitch_sel;
    logic               yaw_neg;
    logic               pitch_neg;
    logic [COORD_W-1:0] distance;
  } c2s_tail_t;

  // Bit-serial quotient, only ever evaluated on constants
  function automatic logic [63:0] div_small(input logic [63:0] num, input logic [7:0] den);
    logic [63:0] quo;
    logic [8:0]  rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[7:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) with 61 fraction bits from the truncated alternating series
  function automatic logic [63:0] atan_step(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          d;
    int          e;
    acc = '0;
    if (i == 0) begin
      return QUARTER_PI_Q61;
    end
    for (int k = 0; k < 32; k++) begin
      d = 2 * k + 1;
      e = i * d;
      if (e <= 63) begin
        term = div_small(64'd1 << (63 - e), 8'(d));
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return (acc + 64'd2) >> 2;
  endfunction

endpackage

// ===== rtl/c2s_front.sv =====
// ----------------------------------------------------------------------------
// c2s_front
// Front end: magnitudes and special-case codes, squares, and the two sums of
// squares, one register stage each.
// ----------------------------------------------------------------------------
module c2s_front (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic signed [c2s_pkg::COORD_W-1:0]         x_i,
  input  logic signed [c2s_pkg::COORD_W-1:0]         y_i,
  input  logic signed [c2s_pkg::COORD_W-1:0]         z_i,
  output logic                                       valid_o,
  output logic [c2s_pkg::LANES-1:0][c2s_pkg::SQ_W-1:0] rad_o,
  output c2s_pkg::c2s_side_t                         side_o
);

  logic [2:0] valid_q;

  c2s_pkg::c2s_side_t s1_side_d, s1_side_q, s2_side_q, s3_side_q;
  logic [c2s_pkg::SQ_W-1:0] sq_x_d, sq_y_d, sq_z_d;
  logic [c2s_pkg::SQ_W-1:0] sq_x_q, sq_y_q, sq_z_q;
  logic [c2s_pkg::LANES-1:0][c2s_pkg::SQ_W-1:0] rad_d, rad_q;

  logic x_neg, y_neg, z_neg, x_zero, y_zero, z_zero;

  assign x_neg  = x_i[c2s_pkg::COORD_W-1];
  assign y_neg  = y_i[c2s_pkg::COORD_W-1];
  assign z_neg  = z_i[c2s_pkg::COORD_W-1];
  assign x_zero = (x_i == '0);
  assign y_zero = (y_i == '0);
  assign z_zero = (z_i == '0);

  always_comb begin
    s1_side_d.ax = x_neg ? (~x_i + c2s_pkg::COORD_W'(1)) : x_i;
    s1_side_d.ay = y_neg ? (~y_i + c2s_pkg::COORD_W'(1)) : y_i;
    s1_side_d.az = z_neg ? (~z_i + c2s_pkg::COORD_W'(1)) : z_i;
    if (y_zero) begin
      s1_side_d.yaw_sel = x_neg ? c2s_pkg::SEL_PI : c2s_pkg::SEL_ZERO;
    end else if (x_zero) begin
      s1_side_d.yaw_sel = c2s_pkg::SEL_HALF_PI;
    end else begin
      s1_side_d.yaw_sel = x_neg ? c2s_pkg::SEL_PI_MINUS : c2s_pkg::SEL_CORDIC;
    end
    if (z_zero) begin
      s1_side_d.pitch_sel = c2s_pkg::SEL_ZERO;
    end else if (x_zero && y_zero) begin
      s1_side_d.pitch_sel = c2s_pkg::SEL_HALF_PI;
    end else begin
      s1_side_d.pitch_sel = c2s_pkg::SEL_CORDIC;
    end
    s1_side_d.yaw_neg   = y_neg;
    s1_side_d.pitch_neg = z_neg;
  end

  assign sq_x_d = c2s_pkg::SQ_W'(s1_side_q.ax) * c2s_pkg::SQ_W'(s1_side_q.ax);
  assign sq_y_d = c2s_pkg::SQ_W'(s1_side_q.ay) * c2s_pkg::SQ_W'(s1_side_q.ay);
  assign sq_z_d = c2s_pkg::SQ_W'(s1_side_q.az) * c2s_pkg::SQ_W'(s1_side_q.az);

  assign rad_d[c2s_pkg::LANE_XY]  = sq_x_q + sq_y_q;
  assign rad_d[c2s_pkg::LANE_XYZ] = sq_x_q + sq_y_q + sq_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= s1_side_d;
      sq_x_q    <= sq_x_d;
      sq_y_q    <= sq_y_d;
      sq_z_q    <= sq_z_d;
      s2_side_q <= s1_side_q;
      rad_q     <= rad_d;
      s3_side_q <= s2_side_q;
    end
  end

  assign valid_o = valid_q[2];
  assign rad_o   = rad_q;
  assign side_o  = s3_side_q;

endmodule

// ===== rtl/c2s_isqrt.sv =====
// ----------------------------------------------------------------------------
// c2s_isqrt
// Pipelined restoring square root, one result bit per stage, two lanes in
// lockstep. Each lane returns floor(sqrt(rad * 4^PRESCALE)).
// ----------------------------------------------------------------------------
module c2s_isqrt (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [c2s_pkg::LANES-1:0][c2s_pkg::SQ_W-1:0]  rad_i,
  input  c2s_pkg::c2s_side_t                            side_i,
  output logic                                          valid_o,
  output logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0] root_o,
  output c2s_pkg::c2s_side_t                            side_o
);

  localparam int N = c2s_pkg::ROOT_W;

  logic [N-1:0]                                   valid_q;
  c2s_pkg::c2s_side_t                             side_q [N];
  logic [c2s_pkg::LANES-1:0][c2s_pkg::SQ_W-1:0]   rad_q  [N];
  logic [c2s_pkg::LANES-1:0][c2s_pkg::REM_W-1:0]  rem_q  [N];
  logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0] root_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int J = N - 1 - s;

    logic                                           src_valid;
    c2s_pkg::c2s_side_t                             src_side;
    logic [c2s_pkg::LANES-1:0][c2s_pkg::SQ_W-1:0]   src_rad;
    logic [c2s_pkg::LANES-1:0][c2s_pkg::REM_W-1:0]  src_rem;
    logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0] src_root;

    if (s == 0) begin : g_first
      assign src_valid = valid_i;
      assign src_side  = side_i;
      assign src_rad   = rad_i;
      assign src_rem   = '0;
      assign src_root  = '0;
    end else begin : g_next
      assign src_valid = valid_q[s-1];
      assign src_side  = side_q[s-1];
      assign src_rad   = rad_q[s-1];
      assign src_rem   = rem_q[s-1];
      assign src_root  = root_q[s-1];
    end

    for (genvar l = 0; l < c2s_pkg::LANES; l++) begin : g_lane
      logic [1:0]                 pair;
      logic [c2s_pkg::REM_W-1:0]  rem_sh, trial, rem_d;
      logic [c2s_pkg::ROOT_W-1:0] root_d;
      logic                       ge;

      // low radicand pairs come from the prescale and are zero
      if (J >= c2s_pkg::PRESCALE) begin : g_pair
        assign pair = src_rad[l][2*(J-c2s_pkg::PRESCALE) +: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end

      assign rem_sh = {src_rem[l][c2s_pkg::REM_W-3:0], pair};
      assign trial  = {src_root[l], 2'b01};
      assign ge     = (rem_sh >= trial);
      assign rem_d  = ge ? (rem_sh - trial) : rem_sh;
      assign root_d = {src_root[l][c2s_pkg::ROOT_W-2:0], ge};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l]  <= rem_d;
          root_q[s][l] <= root_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= src_side;
        rad_q[s]  <= src_rad;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

  // floor root leaves a remainder of at most twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_q[N-1] |->
      (rem_q[N-1][0] <= {root_q[N-1][0], 1'b0}) &&
      (rem_q[N-1][1] <= {root_q[N-1][1], 1'b0}))
    else $error("square root remainder out of range");

endmodule

// ===== rtl/c2s_cordic.sv =====
// ----------------------------------------------------------------------------
// c2s_cordic
// Unrolled vectoring CORDIC, one rotation per stage, two lanes in lockstep,
// followed by a clamp of the angle to [0, pi/2].
// ----------------------------------------------------------------------------
module c2s_cordic (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0] px_i,
  input  logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0] py_i,
  input  c2s_pkg::c2s_tail_t                            tail_i,
  output logic                                          valid_o,
  output logic [c2s_pkg::LANES-1:0][c2s_pkg::ANG_W-1:0] ang_o,
  output c2s_pkg::c2s_tail_t                            tail_o
);

  localparam int N = c2s_pkg::CORDIC_STAGES;

  logic [N-1:0]                                  valid_q;
  c2s_pkg::c2s_tail_t                            tail_q [N];
  logic [c2s_pkg::LANES-1:0][c2s_pkg::CD_W-1:0]  x_q    [N];
  logic [c2s_pkg::LANES-1:0][c2s_pkg::CD_W-1:0]  y_q    [N];
  logic [c2s_pkg::LANES-1:0][c2s_pkg::CD_W-1:0]  z_q    [N];

  logic                                          out_valid_q;
  c2s_pkg::c2s_tail_t                            out_tail_q;
  logic [c2s_pkg::LANES-1:0][c2s_pkg::ANG_W-1:0] ang_d, ang_q;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam logic [c2s_pkg::CD_W-1:0] STEP = c2s_pkg::atan_step(s);

    logic                                         src_valid;
    c2s_pkg::c2s_tail_t                           src_tail;
    logic [c2s_pkg::LANES-1:0][c2s_pkg::CD_W-1:0] src_x, src_y, src_z;

    if (s == 0) begin : g_first
      assign src_valid = valid_i;
      assign src_tail  = tail_i;
      for (genvar l = 0; l < c2s_pkg::LANES; l++) begin : g_load
        assign src_x[l] = c2s_pkg::CD_W'(px_i[l]);
        assign src_y[l] = c2s_pkg::CD_W'(py_i[l]);
        assign src_z[l] = '0;
      end
    end else begin : g_next
      assign src_valid = valid_q[s-1];
      assign src_tail  = tail_q[s-1];
      assign src_x     = x_q[s-1];
      assign src_y     = y_q[s-1];
      assign src_z     = z_q[s-1];
    end

    for (genvar l = 0; l < c2s_pkg::LANES; l++) begin : g_lane
      logic signed [c2s_pkg::CD_W-1:0] xs, ys, zs, dx, dy, x_d, y_d, z_d;

      assign xs = $signed(src_x[l]);
      assign ys = $signed(src_y[l]);
      assign zs = $signed(src_z[l]);
      assign dx = ys >>> s;
      assign dy = xs >>> s;

      // rotate toward the x axis
      always_comb begin
        if (!ys[c2s_pkg::CD_W-1]) begin
          x_d = xs + dx;
          y_d = ys - dy;
          z_d = zs + $signed(STEP);
        end else begin
          x_d = xs - dx;
          y_d = ys + dy;
          z_d = zs - $signed(STEP);
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s][l] <= x_d;
          y_q[s][l] <= y_d;
          z_q[s][l] <= z_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tail_q[s] <= src_tail;
      end
    end
  end

  for (genvar l = 0; l < c2s_pkg::LANES; l++) begin : g_clamp
    always_comb begin
      if (z_q[N-1][l][c2s_pkg::CD_W-1]) begin
        ang_d[l] = '0;
      end else if (z_q[N-1][l] > c2s_pkg::HALF_PI_Q61) begin
        ang_d[l] = c2s_pkg::HALF_PI_Q61;
      end else begin
        ang_d[l] = z_q[N-1][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_tail_q <= tail_q[N-1];
      ang_q      <= ang_d;
    end
  end

  assign valid_o = out_valid_q;
  assign ang_o   = ang_q;
  assign tail_o  = out_tail_q;

endmodule

// ===== rtl/cartesian_to_spherical.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts a Q16.16 position into yaw (Q3.29 radians), pitch (Q2.29 radians) and
// distance (Q16.16) through a square root pipeline and a pair of CORDIC pipelines.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while in_ready_o is high. Each item
// passes through 3 front-end stages, one square root stage per root bit
// (ROOT_W = 60), one stage per CORDIC rotation (CORDIC_STAGES = 24), a clamp
// stage, and three stages of folding, rounding and output; the 60-stage
// square root of x^2 + y^2 feeds the pitch CORDIC.
// When the output is held the pipeline freezes, but it keeps accepting items
// as long as the stage in front of the output register is empty. The block
// keeps no state between items.
module cartesian_to_spherical (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [c2s_pkg::COORD_W-1:0]    x_position_i,
  input  logic signed [c2s_pkg::COORD_W-1:0]    y_position_i,
  input  logic signed [c2s_pkg::COORD_W-1:0]    z_position_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [c2s_pkg::YAW_W-1:0]      yaw_angle_o,
  output logic signed [c2s_pkg::PITCH_W-1:0]    pitch_angle_o,
  output logic [c2s_pkg::COORD_W-1:0]           range_distance_o
);

  logic adv;

  logic                                           fe_valid;
  logic [c2s_pkg::LANES-1:0][c2s_pkg::SQ_W-1:0]   fe_rad;
  c2s_pkg::c2s_side_t                             fe_side;

  logic                                           sq_valid;
  logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0] sq_root;
  c2s_pkg::c2s_side_t                             sq_side;

  logic [c2s_pkg::LANES-1:0][c2s_pkg::ROOT_W-1:0] cd_px, cd_py;
  c2s_pkg::c2s_tail_t                             cd_tail_in;
  logic [c2s_pkg::COORD_W:0]                      dist_sum;

  logic                                           cd_valid;
  logic [c2s_pkg::LANES-1:0][c2s_pkg::ANG_W-1:0]  cd_ang;
  c2s_pkg::c2s_tail_t                             cd_tail;

  logic                          f1_valid_q, f2_valid_q, out_valid_q;
  logic [c2s_pkg::ANG_W-1:0]     yaw_val_d, pitch_val_d, yaw_val_q, pitch_val_q;
  logic [c2s_pkg::ANG_W-1:0]     yaw_sum, pitch_sum;
  logic [c2s_pkg::YAW_W-1:0]     yaw_mag_d, yaw_mag_q;
  logic [c2s_pkg::PITCH_W-1:0]   pitch_mag_d, pitch_mag_q;
  logic                          f1_yaw_neg_q, f1_pitch_neg_q, f2_yaw_neg_q, f2_pitch_neg_q;
  logic [c2s_pkg::COORD_W-1:0]   f1_dist_q, f2_dist_q, dist_q;
  logic [c2s_pkg::YAW_W-1:0]     yaw_q;
  logic [c2s_pkg::PITCH_W-1:0]   pitch_q;

  function automatic logic [c2s_pkg::ANG_W-1:0] fold_angle(
      input c2s_pkg::c2s_sel_e sel, input logic [c2s_pkg::ANG_W-1:0] ang);
    logic [c2s_pkg::ANG_W-1:0] res;
    unique case (sel)
      c2s_pkg::SEL_CORDIC:   res = ang;
      c2s_pkg::SEL_ZERO:     res = '0;
      c2s_pkg::SEL_HALF_PI:  res = c2s_pkg::HALF_PI_Q61;
      c2s_pkg::SEL_PI:       res = c2s_pkg::PI_Q61;
      c2s_pkg::SEL_PI_MINUS: res = c2s_pkg::PI_Q61 - ang;
      default:               res = '0;
    endcase
    return res;
  endfunction

  // advance all stages ahead of the output register unless the output is held and the last stage is full
  assign adv        = !out_valid_q || out_ready_i || !f2_valid_q;
  assign in_ready_o = adv;

  c2s_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .x_i     (x_position_i),
    .y_i     (y_position_i),
    .z_i     (z_position_i),
    .valid_o (fe_valid),
    .rad_o   (fe_rad),
    .side_o  (fe_side)
  );

  c2s_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fe_valid),
    .rad_i   (fe_rad),
    .side_i  (fe_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // distance rounds to nearest: the first bit below the integer part decides
  assign dist_sum = {1'b0, sq_root[c2s_pkg::LANE_XYZ][c2s_pkg::ROOT_W-1:c2s_pkg::PRESCALE]}
                  + (c2s_pkg::COORD_W + 1)'(sq_root[c2s_pkg::LANE_XYZ][c2s_pkg::PRESCALE-1]);

  always_comb begin
    cd_tail_in.yaw_sel   = sq_side.yaw_sel;
    cd_tail_in.pitch_sel = sq_side.pitch_sel;
    cd_tail_in.yaw_neg   = sq_side.yaw_neg;
    cd_tail_in.pitch_neg = sq_side.pitch_neg;
    cd_tail_in.distance  = dist_sum[c2s_pkg::COORD_W] ? '1 : dist_sum[c2s_pkg::COORD_W-1:0];
  end

  assign cd_px[c2s_pkg::LANE_YAW]   = {sq_side.ax, {c2s_pkg::PRESCALE{1'b0}}};
  assign cd_py[c2s_pkg::LANE_YAW]   = {sq_side.ay, {c2s_pkg::PRESCALE{1'b0}}};
  assign cd_px[c2s_pkg::LANE_PITCH] = sq_root[c2s_pkg::LANE_XY];
  assign cd_py[c2s_pkg::LANE_PITCH] = {sq_side.az, {c2s_pkg::PRESCALE{1'b0}}};

  c2s_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .px_i    (cd_px),
    .py_i    (cd_py),
    .tail_i  (cd_tail_in),
    .valid_o (cd_valid),
    .ang_o   (cd_ang),
    .tail_o  (cd_tail)
  );

  assign yaw_val_d   = fold_angle(cd_tail.yaw_sel, cd_ang[c2s_pkg::LANE_YAW]);
  assign pitch_val_d = fold_angle(cd_tail.pitch_sel, cd_ang[c2s_pkg::LANE_PITCH]);

  assign yaw_sum     = yaw_val_q + c2s_pkg::RND_HALF;
  assign pitch_sum   = pitch_val_q + c2s_pkg::RND_HALF;
  assign yaw_mag_d   = yaw_sum[c2s_pkg::RND_SH +: c2s_pkg::YAW_W];
  assign pitch_mag_d = pitch_sum[c2s_pkg::RND_SH +: c2s_pkg::PITCH_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q  <= 1'b0;
      f2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        f1_valid_q <= cd_valid;
        f2_valid_q <= f1_valid_q;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= f2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw_val_q      <= yaw_val_d;
      pitch_val_q    <= pitch_val_d;
      f1_yaw_neg_q   <= cd_tail.yaw_neg;
      f1_pitch_neg_q <= cd_tail.pitch_neg;
      f1_dist_q      <= cd_tail.distance;
      yaw_mag_q      <= yaw_mag_d;
      pitch_mag_q    <= pitch_mag_d;
      f2_yaw_neg_q   <= f1_yaw_neg_q;
      f2_pitch_neg_q <= f1_pitch_neg_q;
      f2_dist_q      <= f1_dist_q;
    end
    if (!out_valid_q || out_ready_i) begin
      yaw_q   <= f2_yaw_neg_q ? (~yaw_mag_q + c2s_pkg::YAW_W'(1)) : yaw_mag_q;
      pitch_q <= f2_pitch_neg_q ? (~pitch_mag_q + c2s_pkg::PITCH_W'(1)) : pitch_mag_q;
      dist_q  <= f2_dist_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign yaw_angle_o      = $signed(yaw_q);
  assign pitch_angle_o    = $signed(pitch_q);
  assign range_distance_o = dist_q;

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (yaw_angle_o <= c2s_pkg::YAW_LIMIT) &&
                      (yaw_angle_o >= -c2s_pkg::YAW_LIMIT))
    else $error("yaw outside minus pi to pi");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (pitch_angle_o <= c2s_pkg::PITCH_LIMIT) &&
                      (pitch_angle_o >= -c2s_pkg::PITCH_LIMIT))
    else $error("pitch outside minus half pi to half pi");

  // zero distance only comes from the origin, where both angles are zero
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (range_distance_o == '0)) |->
      (yaw_angle_o == '0) && (pitch_angle_o == '0))
    else $error("nonzero angle at zero distance");

endmodule
